FILE: hw/rtl/fsf_pkg.sv
// shared types, constants and prefix tables of the frame slice filter
`default_nettype none
package fsf_pkg;

	localparam int INDEX_WIDTH = 32;
	localparam int STEP_W = 32;
	localparam int FRAME_W = 32;
	localparam int CMP_W = (INDEX_WIDTH > STEP_W) ? INDEX_WIDTH : STEP_W;
	localparam int DIV_CNT_W = $clog2(INDEX_WIDTH);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(INDEX_WIDTH - 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END = 2'd2;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam int PFX_COUNT = 5;
	localparam int POS_W = 4;
	localparam logic [POS_W-1:0] POS_MAX = 4'd15;
	localparam logic [7:0] CHAR_NL = 8'h0A;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_PLAIN = 3'd1,
		KIND_FRAME = 3'd2,
		KIND_SECTION = 3'd3,
		KIND_END = 3'd4
	} line_kind_t;

	typedef struct packed {
		logic [7:0] data;
		line_kind_t kind;
	} fsf_entry_t;

	typedef struct packed {
		logic done;
		logic [STEP_W-1:0] rem;
	} fsf_phase_t;

	// prefix text as bytes, padded to one entry per line position
	// order: "#frm ", "#frame ", banner line, "#end ", "#section "
	localparam logic [7:0] PFX_TEXT [PFX_COUNT][16] = '{
		'{8'h23, 8'h66, 8'h72, 8'h6D, 8'h20, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h23, 8'h66, 8'h72, 8'h61, 8'h6D, 8'h65, 8'h20, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h23, 8'h43, 8'h79, 8'h74, 8'h6F, 8'h73, 8'h69, 8'h6D,
		  8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h23, 8'h65, 8'h6E, 8'h64, 8'h20, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h23, 8'h73, 8'h65, 8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E,
		  8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [POS_W-1:0] PFX_LEN [PFX_COUNT] = '{4'd5, 4'd7, 4'd9, 4'd5, 4'd9};
	localparam line_kind_t PFX_KIND [PFX_COUNT] =
		'{KIND_FRAME, KIND_FRAME, KIND_FRAME, KIND_END, KIND_SECTION};

endpackage
`default_nettype wire

FILE: hw/rtl/frame_slice_filter.sv
// top level: frame slice filter over a text byte stream
// path: an accepted input beat is queued, then popped into the result register
// throughput: one byte per cycle, set by the single back-end update of the frame index
// while out_stall is low and the phase unit is idle; after a configuration write
// the back end waits for the phase unit; input beats are still queued (queue of two)
// reset: asynchronous, clears control and loads register defaults; no clearing pass
`default_nettype none
module frame_slice_filter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [fsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fsf_pkg::STEP_W-1:0]     cfg_wdata,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     in_byte,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          out_byte,
	output logic                                keep,
	output logic [2:0]                          line_kind,
	output logic [fsf_pkg::FRAME_W-1:0]         frame_index,
	output logic                                done_res
);

	// slice registers
	logic [fsf_pkg::STEP_W-1:0] start_q;
	logic [fsf_pkg::STEP_W-1:0] step_q;
	logic [fsf_pkg::STEP_W-1:0] end_q;

	// front to queue
	logic push;
	fsf_pkg::fsf_entry_t push_entry;
	// queue to back
	logic pop, q_full, q_empty;
	fsf_pkg::fsf_entry_t pop_entry;
	// phase unit
	logic div_busy;
	fsf_pkg::fsf_phase_t div_res;
	logic [fsf_pkg::INDEX_WIDTH-1:0] frame_count;

	// register writes; a zero step is held as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			step_q <= fsf_pkg::STEP_W'(1);
			end_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				fsf_pkg::REG_START: start_q <= cfg_wdata;
				fsf_pkg::REG_STEP: step_q <= (cfg_wdata == '0) ? fsf_pkg::STEP_W'(1) : cfg_wdata;
				fsf_pkg::REG_END: end_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// prefix tracking and line classification
	fsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_byte    (in_byte),
		.in_stall   (in_stall),
		.queue_full (q_full),
		.push       (push),
		.entry      (push_entry)
	);

	// decouples input acceptance from result backpressure
	fsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.entry_in  (push_entry),
		.pop       (pop),
		.entry_out (pop_entry),
		.full      (q_full),
		.empty     (q_empty)
	);

	// rebuilds the running slice phase after any register write
	fsf_phase_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (cfg_we),
		.frame_count (frame_count),
		.slice_start (start_q),
		.slice_step  (step_q),
		.busy        (div_busy),
		.result      (div_res)
	);

	// frame index, keep decision, done flag, result beat
	fsf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (q_empty),
		.entry       (pop_entry),
		.pop         (pop),
		.slice_start (start_q),
		.slice_step  (step_q),
		.slice_end   (end_q),
		.div_busy    (div_busy),
		.div_res     (div_res),
		.count       (frame_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.keep        (keep),
		.line_kind   (line_kind),
		.frame_index (frame_index),
		.done_res    (done_res)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/fsf_front.sv
// front end: takes input beats, tracks line prefixes, classifies newlines
`default_nettype none
module fsf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [7:0]         in_byte,
	output logic                    in_stall,
	input  wire logic               queue_full,
	output logic                    push,
	output fsf_pkg::fsf_entry_t     entry
);

	logic [fsf_pkg::POS_W-1:0] pos_q;
	logic [fsf_pkg::PFX_COUNT-1:0] alive_q;
	logic [fsf_pkg::PFX_COUNT-1:0] alive_next;
	fsf_pkg::line_kind_t kind;
	logic is_nl;

	assign is_nl = (in_byte == fsf_pkg::CHAR_NL);
	assign in_stall = queue_full;
	assign push = in_valid && !queue_full;

	always_comb begin
		alive_next = alive_q;
		for (int k = 0; k < fsf_pkg::PFX_COUNT; k++) begin
			if (pos_q < fsf_pkg::PFX_LEN[k] && in_byte != fsf_pkg::PFX_TEXT[k][pos_q]) begin
				alive_next[k] = 1'b0;
			end
		end
		// first surviving prefix wins
		kind = fsf_pkg::KIND_PLAIN;
		for (int k = fsf_pkg::PFX_COUNT - 1; k >= 0; k--) begin
			if (alive_next[k]) begin
				kind = fsf_pkg::PFX_KIND[k];
			end
		end
		entry.data = in_byte;
		entry.kind = is_nl ? kind : fsf_pkg::KIND_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			alive_q <= '1;
		end else if (push) begin
			if (is_nl) begin
				pos_q <= '0;
				alive_q <= '1;
			end else begin
				alive_q <= alive_next;
				if (pos_q != fsf_pkg::POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/fsf_queue.sv
// short queue of classified beats between front and back
`default_nettype none
module fsf_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire fsf_pkg::fsf_entry_t entry_in,
	input  wire logic                pop,
	output fsf_pkg::fsf_entry_t      entry_out,
	output logic                     full,
	output logic                     empty
);

	fsf_pkg::fsf_entry_t mem [fsf_pkg::Q_DEPTH];
	logic [fsf_pkg::Q_PTR_W-1:0] wptr_q;
	logic [fsf_pkg::Q_PTR_W-1:0] rptr_q;
	logic [fsf_pkg::Q_CNT_W-1:0] cnt_q;

	assign full = (cnt_q == fsf_pkg::Q_CNT_W'(fsf_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign entry_out = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == fsf_pkg::Q_PTR_W'(fsf_pkg::Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == fsf_pkg::Q_PTR_W'(fsf_pkg::Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/fsf_phase_div.sv
// restoring remainder unit: (frame index - start) mod step, one bit a cycle
`default_nettype none
module fsf_phase_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [fsf_pkg::INDEX_WIDTH-1:0]  frame_count,
	input  wire logic [fsf_pkg::STEP_W-1:0]       slice_start,
	input  wire logic [fsf_pkg::STEP_W-1:0]       slice_step,
	output logic                                  busy,
	output fsf_pkg::fsf_phase_t                   result
);

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_LOAD,
		DIV_RUN
	} div_state_t;

	div_state_t state_q;
	logic [fsf_pkg::INDEX_WIDTH-1:0] dvd_q;
	logic [fsf_pkg::STEP_W-1:0] rem_q;
	logic [fsf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [fsf_pkg::STEP_W:0] trial;
	logic fits;
	logic [fsf_pkg::STEP_W-1:0] rem_step;
	logic [fsf_pkg::INDEX_WIDTH-1:0] diff;
	logic last;

	assign diff = fsf_pkg::INDEX_WIDTH'(fsf_pkg::CMP_W'(frame_count)
		- fsf_pkg::CMP_W'(slice_start));
	assign trial = {rem_q, dvd_q[fsf_pkg::INDEX_WIDTH-1]};
	assign fits = (trial >= {1'b0, slice_step});
	assign rem_step = fits ? fsf_pkg::STEP_W'(trial - {1'b0, slice_step})
		: trial[fsf_pkg::STEP_W-1:0];
	assign last = (cnt_q == fsf_pkg::DIV_LAST);
	assign busy = (state_q != DIV_IDLE);
	assign result.done = (state_q == DIV_RUN) && last;
	assign result.rem = rem_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q <= '0;
		end else if (start) begin
			state_q <= DIV_LOAD;
		end else begin
			case (state_q)
				DIV_LOAD: begin
					dvd_q <= diff;
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= DIV_RUN;
				end
				DIV_RUN: begin
					dvd_q <= {dvd_q[fsf_pkg::INDEX_WIDTH-2:0], 1'b0};
					rem_q <= rem_step;
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= DIV_IDLE;
					end
				end
				default: begin
					state_q <= DIV_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/fsf_back.sv
// back end: frame counting, slice test, done flag and result register
`default_nettype none
module fsf_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             empty,
	input  wire fsf_pkg::fsf_entry_t              entry,
	output logic                                  pop,
	input  wire logic [fsf_pkg::STEP_W-1:0]       slice_start,
	input  wire logic [fsf_pkg::STEP_W-1:0]       slice_step,
	input  wire logic [fsf_pkg::STEP_W-1:0]       slice_end,
	input  wire logic                             div_busy,
	input  wire fsf_pkg::fsf_phase_t              div_res,
	output logic [fsf_pkg::INDEX_WIDTH-1:0]       count,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [7:0]                            out_byte,
	output logic                                  keep,
	output logic [2:0]                            line_kind,
	output logic [fsf_pkg::FRAME_W-1:0]           frame_index,
	output logic                                  done_res
);

	logic [fsf_pkg::INDEX_WIDTH-1:0] count_q, count_d, next_cnt;
	logic [fsf_pkg::STEP_W-1:0] phase_q, phase_d;
	logic [fsf_pkg::STEP_W:0] phase_inc;
	logic fin_q, fin_d;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_keep_q, keep_d;
	fsf_pkg::line_kind_t out_kind_q, kind_d;
	logic [fsf_pkg::FRAME_W-1:0] out_index_q;
	logic out_done_q;
	logic [fsf_pkg::CMP_W-1:0] n_ext, next_ext, start_ext, end_ext;
	logic ge_start, gt_end, next_gt_end, next_is_start, carry, phase_wrap;

	assign n_ext = fsf_pkg::CMP_W'(count_q);
	assign next_cnt = count_q + 1'b1;
	assign next_ext = fsf_pkg::CMP_W'(next_cnt);
	assign start_ext = fsf_pkg::CMP_W'(slice_start);
	assign end_ext = fsf_pkg::CMP_W'(slice_end);
	assign ge_start = (n_ext >= start_ext);
	assign gt_end = (n_ext > end_ext);
	assign next_gt_end = (next_ext > end_ext);
	assign next_is_start = (next_ext == start_ext);
	assign carry = &count_q;
	assign phase_inc = {1'b0, phase_q} + 1'b1;
	assign phase_wrap = (phase_inc == {1'b0, slice_step});

	assign pop = !empty && !div_busy && (!out_valid_q || !out_stall);

	always_comb begin
		count_d = count_q;
		fin_d = fin_q;
		phase_d = phase_q;
		keep_d = 1'b0;
		kind_d = fsf_pkg::KIND_NONE;
		if (div_res.done) begin
			phase_d = div_res.rem;
		end
		if (pop && !fin_q) begin
			keep_d = ge_start && !gt_end && (phase_q == '0);
			kind_d = entry.kind;
			case (entry.kind)
				fsf_pkg::KIND_FRAME: begin
					if (gt_end) begin
						fin_d = 1'b1;
					end
				end
				fsf_pkg::KIND_END: begin
					count_d = next_cnt;
					if (carry || next_gt_end) begin
						fin_d = 1'b1;
					end
					if (next_is_start || phase_wrap) begin
						phase_d = '0;
					end else begin
						phase_d = phase_inc[fsf_pkg::STEP_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= '0;
			fin_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			phase_q <= phase_d;
			fin_q <= fin_d;
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q <= entry.data;
			out_keep_q <= keep_d;
			out_kind_q <= kind_d;
			out_index_q <= fsf_pkg::FRAME_W'(count_d);
			out_done_q <= fin_d;
		end
	end

	assign count = count_q;
	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign keep = out_keep_q;
	assign line_kind = out_kind_q;
	assign frame_index = out_index_q;
	assign done_res = out_done_q;

	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q)
		else $error("done flag cleared outside reset");

	a_fin_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fin_q) |-> $past(pop))
		else $error("done flag set without a beat");

	a_count_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(pop && entry.kind == fsf_pkg::KIND_END))
		else $error("frame index moved without an end line");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		!div_busy && ge_start |-> phase_q < slice_step)
		else $error("slice phase out of range");

endmodule
`default_nettype wire
